// ----- hw/rtl/epfi_pkg.sv -----
// Shared widths, constants, register indexes and saturation helper for the price lattice core.
package epfi_pkg;

  localparam int RATE_W  = 23;
  localparam int PRICE_W = 32;
  localparam int PROB_W  = 17;
  localparam int STEPS_W = 8;
  localparam int CFG_W   = 17;
  localparam int CFG_IDX_W = 1;
  localparam int QUOT_W  = 33;
  localparam int DIVR_W  = 24;
  localparam int DIV_STEPS = 33;
  localparam int DIV_CNT_W = 6;

  localparam logic [PRICE_W-1:0] ONE_Q31   = 32'h8000_0000;
  localparam logic [DIVR_W-1:0]  PCT_SCALE = 24'd6553600;
  // 6553600 / 2, remaining numerator bits are all zero
  localparam logic [DIVR_W-1:0]  DIV_SEED  = 24'd3276800;
  localparam logic [PROB_W-1:0]  PROB_ONE  = 17'h1_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_UP_PROB = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS   = 1'b1;

  // Clamp a 33-bit sum to 1.0 in Q1.31
  function automatic logic [PRICE_W-1:0] sat_one(input logic [PRICE_W:0] v);
    logic [PRICE_W-1:0] r;
    if (v > {1'b0, ONE_Q31}) begin
      r = ONE_Q31;
    end else begin
      r = v[PRICE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/elementary_price_forward_induction_core.sv -----
// Elementary price lattice by forward induction: sequencer, price row memory, output register.
// A rate word is taken only in the idle state, so the next one waits for all the steps of the
// last: accept, divider steps, divider finish, three passes through the shared multiplier,
// carry swap, output load. A rate that closes a row adds an output load for the edge word.
// A stalled output word holds the sequencer, and so the input, until it is taken.
// Reset: q = 0.5, steps = 255, row 1 with root price 1.0; row memory needs no clearing pass.
module elementary_price_forward_induction_core #(
  parameter int MAX_STEPS = 255,
  localparam int IdxW = $clog2(MAX_STEPS + 2)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [epfi_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [epfi_pkg::CFG_W-1:0]     cfg_data_i,
  // rate words in
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [epfi_pkg::RATE_W-1:0]    short_rate_i,
  // price words out
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [epfi_pkg::PRICE_W-1:0]   price_o,
  output logic [IdxW-1:0]                row_o,
  output logic [IdxW-1:0]                col_o,
  output logic [epfi_pkg::PRICE_W-1:0]   bond_price_o,
  output logic                           row_end_o,
  output logic                           lattice_done_o
);
  import epfi_pkg::*;

  localparam int Depth = MAX_STEPS + 2;
  localparam int CmpW  = (IdxW > 9) ? IdxW + 1 : 10;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_MUL_A, S_MUL_Q, S_MUL_C, S_CARRY, S_OUT_NODE, S_OUT_EDGE
  } state_e;

  state_e state_q;

  // config
  logic [PROB_W-1:0]  up_prob_q;
  logic [STEPS_W-1:0] steps_q;

  // lattice position and running sums
  logic [IdxW-1:0]    row_q;
  logic [IdxW-1:0]    node_q;
  logic [PRICE_W-1:0] carry_q;
  logic [PRICE_W-1:0] row_sum_q;

  // datapath holding registers
  logic [PRICE_W-1:0] a_q;
  logic [PRICE_W-1:0] p_q;

  // output register
  logic               out_valid_q;
  logic [PRICE_W-1:0] price_q;
  logic [IdxW-1:0]    row_out_q;
  logic [IdxW-1:0]    col_q;
  logic [PRICE_W-1:0] bond_q;
  logic               row_end_q;
  logic               done_q;

  // price row memory
  logic [PRICE_W-1:0] price_mem_q [Depth];
  logic [PRICE_W-1:0] rd_data_q;
  logic               mem_we;
  logic [IdxW-1:0]    mem_waddr;
  logic [PRICE_W-1:0] mem_wdata;

  // shared units
  logic                  in_acc;
  logic                  div_done;
  logic [QUOT_W-1:0]     quot;
  logic [PRICE_W-1:0]    mul_a;
  logic [PRICE_W-1:0]    mul_b;
  logic [2*PRICE_W-1:0]  prod;

  logic [PROB_W-1:0]  q_eff;
  logic [PROB_W-1:0]  nq;
  logic [PRICE_W-1:0] z;
  logic [PRICE_W-1:0] a_now;
  logic [PRICE_W-1:0] node_price;
  logic [PRICE_W-1:0] edge_price;
  logic [PRICE_W-1:0] sum_node;
  logic [PRICE_W-1:0] sum_edge;
  logic [IdxW-1:0]    node_nx;
  logic [CmpW-1:0]    steps_ext;
  logic [CmpW-1:0]    n_c;
  logic               last_row;
  logic               out_free;
  logic               out_load;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = out_free && (state_q == S_OUT_NODE || state_q == S_OUT_EDGE);

  // q above one acts as one
  assign q_eff = up_prob_q[PROB_W-1] ? PROB_ONE : up_prob_q;
  assign nq    = PROB_ONE - q_eff;

  // N clamped to 1..MAX_STEPS
  assign steps_ext = CmpW'(steps_q);
  always_comb begin
    if (steps_ext == '0) begin
      n_c = CmpW'(1);
    end else if (steps_ext > CmpW'(MAX_STEPS)) begin
      n_c = CmpW'(MAX_STEPS);
    end else begin
      n_c = steps_ext;
    end
  end
  assign last_row = CmpW'(row_q) >= (n_c + CmpW'(1));

  // root row reads 1.0 without touching the memory
  assign z = (row_q == IdxW'(1)) ? ONE_Q31 : rd_data_q;

  // discount factor of exactly one skips the product
  assign a_now = quot[QUOT_W-1] ? z : prod[2*PRICE_W-1:PRICE_W];

  assign node_price = sat_one({1'b0, carry_q} + {1'b0, p_q});
  assign sum_node   = sat_one({1'b0, row_sum_q} + {1'b0, p_q});
  assign edge_price = sat_one({1'b0, carry_q});
  assign sum_edge   = sat_one({1'b0, row_sum_q} + {1'b0, edge_price});
  assign node_nx    = node_q + IdxW'(1);

  // multiplier operand select
  always_comb begin
    case (state_q)
      S_MUL_A: begin
        mul_a = z;
        mul_b = quot[PRICE_W-1:0];
      end
      S_MUL_Q: begin
        mul_a = a_now;
        mul_b = PRICE_W'(q_eff);
      end
      default: begin
        mul_a = a_q;
        mul_b = PRICE_W'(nq);
      end
    endcase
  end

  epfi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_acc),
    .rate_i (short_rate_i),
    .done_o (div_done),
    .quot_o (quot)
  );

  epfi_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  // memory write port: node word then edge word
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = node_q;
    mem_wdata = p_q;
    if (out_free) begin
      if (state_q == S_OUT_NODE) begin
        mem_we = 1'b1;
      end else if (state_q == S_OUT_EDGE) begin
        mem_we    = 1'b1;
        mem_waddr = row_q;
        mem_wdata = edge_price;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      price_mem_q[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rd_data_q <= price_mem_q[node_q];
    end
  end

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_prob_q <= 17'd32768;
      steps_q   <= 8'd255;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_UP_PROB: up_prob_q <= cfg_data_i;
        CFG_STEPS:   steps_q   <= cfg_data_i[STEPS_W-1:0];
        default:     ;
      endcase
    end
  end

  // sequencer, lattice state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_q       <= IdxW'(1);
      node_q      <= '0;
      carry_q     <= '0;
      row_sum_q   <= '0;
      a_q         <= '0;
      p_q         <= '0;
      out_valid_q <= 1'b0;
      price_q     <= '0;
      row_out_q   <= '0;
      col_q       <= '0;
      bond_q      <= '0;
      row_end_q   <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_MUL_A;
          end
        end
        S_MUL_A: state_q <= S_MUL_Q;
        S_MUL_Q: begin
          a_q     <= a_now;
          state_q <= S_MUL_C;
        end
        S_MUL_C: begin
          // q*a lands here; park it until the carry is swapped in
          p_q     <= prod[PRICE_W+15:16];
          state_q <= S_CARRY;
        end
        S_CARRY: begin
          p_q     <= node_price;
          carry_q <= prod[PRICE_W+15:16];
          state_q <= S_OUT_NODE;
        end
        S_OUT_NODE: begin
          if (out_free) begin
            price_q     <= p_q;
            row_out_q   <= row_q;
            col_q       <= node_q;
            bond_q      <= '0;
            row_end_q   <= 1'b0;
            done_q      <= 1'b0;
            row_sum_q   <= sum_node;
            if (node_nx >= row_q) begin
              state_q <= S_OUT_EDGE;
            end else begin
              node_q  <= node_nx;
              state_q <= S_IDLE;
            end
          end
        end
        S_OUT_EDGE: begin
          if (out_free) begin
            price_q     <= edge_price;
            row_out_q   <= row_q;
            col_q       <= row_q;
            bond_q      <= sum_edge;
            row_end_q   <= 1'b1;
            done_q      <= last_row;
            node_q      <= '0;
            carry_q     <= '0;
            row_sum_q   <= '0;
            row_q       <= last_row ? IdxW'(1) : row_q + IdxW'(1);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign price_o        = price_q;
  assign row_o          = row_out_q;
  assign col_o          = col_q;
  assign bond_price_o   = bond_q;
  assign row_end_o      = row_end_q;
  assign lattice_done_o = done_q;

  // node index always inside the current row
  a_node_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    node_q < row_q)
    else $error("node index past row");

  // divider finishes only while the sequencer waits on it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider done outside wait state");

  // edge word carries its row index as column
  a_edge_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && row_end_o |-> col_o == row_o)
    else $error("edge word column mismatch");

  // end of lattice only on an edge word, and the lattice restarts at row one
  a_done_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && lattice_done_o |-> row_end_o && row_q == IdxW'(1))
    else $error("lattice end without restart");

endmodule

// ----- hw/rtl/epfi_div.sv -----
// Restoring divider, one quotient bit per cycle: 6553600 * 2^32 / (6553600 + rate).
module epfi_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [epfi_pkg::RATE_W-1:0]  rate_i,
  output logic                         done_o,
  output logic [epfi_pkg::QUOT_W-1:0]  quot_o
);
  import epfi_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIVR_W-1:0]    divr_q, divr_d;
  logic [DIVR_W-1:0]    rem_q, rem_d;
  logic [QUOT_W-1:0]    quot_q, quot_d;
  logic [DIVR_W:0]      rem_sh;
  logic [DIVR_W:0]      diff;

  assign rem_sh = {rem_q, 1'b0};
  assign diff   = rem_sh - {1'b0, divr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    divr_d = divr_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_STEPS);
      divr_d = PCT_SCALE + DIVR_W'(rate_i);
      rem_d  = DIV_SEED;
    end else if (busy_q) begin
      if (diff[DIVR_W]) begin
        rem_d  = rem_sh[DIVR_W-1:0];
        quot_d = {quot_q[QUOT_W-2:0], 1'b0};
      end else begin
        rem_d  = diff[DIVR_W-1:0];
        quot_d = {quot_q[QUOT_W-2:0], 1'b1};
      end
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    divr_q <= divr_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- hw/rtl/epfi_mul.sv -----
// Shared 32x32 multiplier with registered product.
module epfi_mul (
  input  logic                          clk_i,
  input  logic [epfi_pkg::PRICE_W-1:0]  a_i,
  input  logic [epfi_pkg::PRICE_W-1:0]  b_i,
  output logic [2*epfi_pkg::PRICE_W-1:0] prod_o
);
  import epfi_pkg::*;

  logic [2*PRICE_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// ----- tb/tb.sv -----
// Testbench for the forward-induction elementary price core: directed and random rate words, self-checking.
`timescale 1ns / 1ps

module tb;
  import epfi_pkg::*;

  localparam int LAT_MAX      = 255;
  localparam int IDX_W        = $clog2(LAT_MAX + 2);
  localparam int SETTLE_CYC   = 60;
  localparam int RATE_TARGET  = 600;
  localparam int HOLD_AT_WORD = 80;      // output word count that triggers the long hold-off
  localparam int HOLD_CYC     = 600;
  localparam int IDLE_LIMIT   = 4000;    // cycles without any handshake before giving up

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [PRICE_W-1:0] bond;
    logic               row_end;
    logic               done;
  } price_word_t;

  // DUT ports, known from time zero
  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i    = CFG_UP_PROB;
  logic [CFG_W-1:0]     cfg_data_i   = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [RATE_W-1:0]    short_rate_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [PRICE_W-1:0]   price_o;
  logic [IDX_W-1:0]     row_o;
  logic [IDX_W-1:0]     col_o;
  logic [PRICE_W-1:0]   bond_price_o;
  logic                 row_end_o;
  logic                 lattice_done_o;

  elementary_price_forward_induction_core #(
    .MAX_STEPS(LAT_MAX)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .short_rate_i  (short_rate_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .price_o       (price_o),
    .row_o         (row_o),
    .col_o         (col_o),
    .bond_price_o  (bond_price_o),
    .row_end_o     (row_end_o),
    .lattice_done_o(lattice_done_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Lattice predictor: own copy of registers and row state
  // ---------------------------------------------------------------------------
  logic [PROB_W-1:0]  q_weight;
  logic [STEPS_W-1:0] lat_steps;
  logic [PRICE_W-1:0] node_price [0:LAT_MAX+1];
  logic [PRICE_W-1:0] carry_in;
  logic [PRICE_W-1:0] row_total;
  int unsigned        cur_row;
  int unsigned        cur_node;

  price_word_t       due_words [$];   // price words still to come out, oldest first
  logic [RATE_W-1:0] rate_q [$];      // rate words waiting for the driver
  int                mismatches = 0;
  int                words_seen = 0;

  function automatic logic [PRICE_W-1:0] clip_one(input logic [63:0] v);
    return (v > 64'(ONE_Q31)) ? ONE_Q31 : v[PRICE_W-1:0];
  endfunction

  function automatic void restart_lattice();
    for (int k = 0; k <= LAT_MAX + 1; k++) node_price[k] = '0;
    node_price[0] = ONE_Q31;
    carry_in  = '0;
    row_total = '0;
    cur_row   = 1;
    cur_node  = 0;
  endfunction

  // One rate word in: the node it completes, plus the edge node when the row closes
  function automatic void advance_lattice(input logic [RATE_W-1:0] rate);
    logic [63:0]        disc, disc_price, stay_part, move_part;
    logic [PROB_W-1:0]  q;
    int unsigned        n, j, e;
    logic [PRICE_W-1:0] p;
    price_word_t        w;
    q = (q_weight > PROB_ONE) ? PROB_ONE : q_weight;   // q above one acts as one
    n = (lat_steps == 0) ? 1 : lat_steps;
    if (n > LAT_MAX) n = LAT_MAX;
    j = (cur_node > LAT_MAX) ? LAT_MAX : cur_node;

    // Q1.32 discount factor 1 / (1 + r/100), truncated
    disc       = (64'(PCT_SCALE) << 32) / (64'(PCT_SCALE) + 64'(rate));
    disc_price = (64'(node_price[j]) * disc) >> 32;
    stay_part  = (disc_price * 64'(q)) >> 16;
    move_part  = (disc_price * (64'd65536 - 64'(q))) >> 16;

    p             = clip_one(64'(carry_in) + stay_part);
    node_price[j] = p;
    row_total     = clip_one(64'(row_total) + 64'(p));
    carry_in      = move_part[PRICE_W-1:0];
    w.price   = p;
    w.row     = cur_row[IDX_W-1:0];
    w.col     = j[IDX_W-1:0];
    w.bond    = '0;
    w.row_end = 1'b0;
    w.done    = 1'b0;
    due_words.push_back(w);

    cur_node = j + 1;
    if (cur_node >= cur_row) begin
      // edge node closes the row; steps is read here, so a mid-lattice cut ends it early
      e = (cur_row > LAT_MAX + 1) ? LAT_MAX + 1 : cur_row;
      p             = clip_one(64'(carry_in));
      node_price[e] = p;
      row_total     = clip_one(64'(row_total) + 64'(p));
      w.price   = p;
      w.row     = cur_row[IDX_W-1:0];
      w.col     = e[IDX_W-1:0];
      w.bond    = row_total;
      w.row_end = 1'b1;
      w.done    = (cur_row >= n + 1);
      due_words.push_back(w);
      if (w.done) begin
        restart_lattice();
      end else begin
        cur_row++;
        cur_node  = 0;
        carry_in  = '0;
        row_total = '0;
      end
    end
  endfunction

  // Random per-word wait, with occasional stretches of back-to-back words
  function automatic int draw_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) quiet_left = $urandom_range(20, 40);
    return $urandom_range(0, 17);
  endfunction

  // ---------------------------------------------------------------------------
  // Rate driver
  // ---------------------------------------------------------------------------
  int drv_wait  = 0;
  int drv_quiet = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      short_rate_i <= '0;
      drv_wait = 0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        // word taken at this edge
        advance_lattice(short_rate_i);
        drv_wait = draw_gap(drv_quiet);
      end
      if (drv_wait > 0) begin
        drv_wait--;
        in_valid_i <= 1'b0;
      end else if (rate_q.size() > 0) begin
        in_valid_i   <= 1'b1;
        short_rate_i <= rate_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Price word monitor; holds off once for a long stretch to back the core up
  // ---------------------------------------------------------------------------
  int mon_wait  = 0;
  int mon_quiet = 0;
  int hold_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    price_word_t exp_w;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        words_seen++;
        if (due_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word price=%h row=%0d col=%0d bond=%h end=%b done=%b",
                   $time, price_o, row_o, col_o, bond_price_o, row_end_o, lattice_done_o);
        end else begin
          exp_w = due_words.pop_front();
          if (price_o !== exp_w.price || row_o !== exp_w.row || col_o !== exp_w.col ||
              bond_price_o !== exp_w.bond || row_end_o !== exp_w.row_end ||
              lattice_done_o !== exp_w.done) begin
            mismatches++;
            $display("%0t: mismatch exp price=%h row=%0d col=%0d bond=%h end=%b done=%b",
                     $time, exp_w.price, exp_w.row, exp_w.col, exp_w.bond,
                     exp_w.row_end, exp_w.done);
            $display("%0t: mismatch got price=%h row=%0d col=%0d bond=%h end=%b done=%b",
                     $time, price_o, row_o, col_o, bond_price_o, row_end_o, lattice_done_o);
          end
        end
        mon_wait = draw_gap(mon_quiet);
        if (words_seen == HOLD_AT_WORD) hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (mon_wait > 0) begin
        mon_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: no handshake on either side for too long
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_UP_PROB) q_weight = val[PROB_W-1:0];
    else                    lat_steps = val[STEPS_W-1:0];
  endtask

  // all rate words taken and every price word back, then a short pause
  task automatic wait_drained(input int pause);
    @(negedge clk_i);
    while (rate_q.size() != 0 || in_valid_i || due_words.size() != 0) @(negedge clk_i);
    repeat (pause) @(negedge clk_i);
  endtask

  function automatic logic [RATE_W-1:0] draw_rate();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return RATE_W'($urandom);
      default: return RATE_W'($urandom_range(0, 1310720));  // up to 20 percent
    endcase
  endfunction

  initial begin
    int rates_planned;
    int burst;
    int pick;
    logic [CFG_W-1:0] q_val;
    logic [CFG_W-1:0] n_val;

    q_weight  = 17'd32768;
    lat_steps = 8'd255;
    restart_lattice();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // reset settings (q one half, 255 steps): first three rows, rate extremes
    rate_q.push_back('0);
    rate_q.push_back('1);
    rate_q.push_back('0);
    rate_q.push_back(RATE_W'(PCT_SCALE));   // exactly 100 percent
    rate_q.push_back('1);
    rate_q.push_back(23'd1);
    wait_drained(SETTLE_CYC);

    // steps cut below the current row mid-lattice, q to zero: row 4 closes the lattice
    write_reg(CFG_UP_PROB, 17'd0);
    write_reg(CFG_STEPS, 17'd2);
    rate_q.push_back('0);
    rate_q.push_back('0);
    rate_q.push_back('1);
    rate_q.push_back(23'd123456);
    wait_drained(SETTLE_CYC);

    // q of one, zero steps treated as one step
    write_reg(CFG_UP_PROB, PROB_ONE);
    write_reg(CFG_STEPS, 17'd0);
    rate_q.push_back('0);
    rate_q.push_back(23'h2AAAAA);
    rate_q.push_back(23'h555555);
    wait_drained(SETTLE_CYC);

    // largest register value for q, which saturates to one
    write_reg(CFG_UP_PROB, '1);
    write_reg(CFG_STEPS, 17'd1);
    repeat (3) rate_q.push_back(draw_rate());
    wait_drained(SETTLE_CYC);

    // q above one but not all ones, q changed between rows of the same lattice
    write_reg(CFG_UP_PROB, 17'd70000);
    write_reg(CFG_STEPS, 17'd2);
    repeat (3) rate_q.push_back(draw_rate());
    wait_drained(SETTLE_CYC);
    write_reg(CFG_UP_PROB, 17'd16384);
    repeat (3) rate_q.push_back(draw_rate());
    wait_drained(SETTLE_CYC);

    // random phases: new settings, lattice state carried across each write
    rates_planned = 0;
    while (rates_planned < RATE_TARGET) begin
      pick = $urandom_range(0, 7);
      case (pick)
        0:       q_val = '0;
        1:       q_val = PROB_ONE;
        2:       q_val = CFG_W'($urandom_range(0, 131071));
        default: q_val = CFG_W'($urandom_range(0, 65536));
      endcase
      pick = $urandom_range(0, 7);
      case (pick)
        0:       n_val = 17'd255;
        1:       n_val = CFG_W'($urandom_range(7, 24));
        default: n_val = CFG_W'($urandom_range(0, 6));
      endcase
      if ($urandom_range(0, 3) != 0) write_reg(CFG_UP_PROB, q_val);
      write_reg(CFG_STEPS, n_val);
      burst = $urandom_range(20, 120);
      repeat (burst) rate_q.push_back(draw_rate());
      rates_planned += burst;
      wait_drained(SETTLE_CYC);
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/epfi_pkg.sv
hw/rtl/epfi_div.sv
hw/rtl/epfi_mul.sv
hw/rtl/elementary_price_forward_induction_core.sv
tb/tb.sv
